@@ hw/rtl/pyuv420_pkg.sv @@
// Shared types and constants for the packed 4:2:2 to planar 4:2:0 converter.
`default_nettype none

package pyuv420_pkg;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_GROUPS_PER_ROW = 2'd0;
    localparam logic [1:0] REG_INTERLACED     = 2'd1;
    localparam logic [1:0] REG_UYVY_ORDER     = 2'd2;

    localparam logic [11:0] GROUPS_PER_ROW_RST = 12'd960;

    typedef struct packed {
        logic [11:0] groups_per_row;
        logic        interlaced;
        logic        uyvy_order;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/pyuv420_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pyuv420_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/pyuv420_cfg.sv @@
// APB register block: row length, interlace mode and byte order.
`default_nettype none

module pyuv420_cfg
    import pyuv420_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_GROUPS_PER_ROW: n_cfg.groups_per_row = pwdata[11:0];
                REG_INTERLACED:     n_cfg.interlaced     = pwdata[0];
                REG_UYVY_ORDER:     n_cfg.uyvy_order     = pwdata[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.groups_per_row <= GROUPS_PER_ROW_RST;
            r_cfg.interlaced     <= 1'b0;
            r_cfg.uyvy_order     <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GROUPS_PER_ROW: prdata = APB_DW'(r_cfg.groups_per_row);
            REG_INTERLACED:     prdata = APB_DW'(r_cfg.interlaced);
            REG_UYVY_ORDER:     prdata = APB_DW'(r_cfg.uyvy_order);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/pyuv420_pos.sv @@
// Column and row tracker: position of the current macropixel and row pairing.
`default_nettype none

module pyuv420_pos
    import pyuv420_pkg::*;
#(
    parameter int MAX_GROUPS = 2048,
    parameter int MAX_ROWS   = 4096,
    localparam int CW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
    localparam int RW = $clog2(MAX_ROWS),
    localparam int LW = $clog2(MAX_GROUPS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_advance,
    input  wire logic          i_frame_start,
    input  wire t_cfg          i_cfg,
    output logic      [CW-1:0] o_col,
    output logic      [RW-1:0] o_row,
    output logic               o_lower,
    output logic               o_slot
);

    logic [CW-1:0] r_col, n_col, c0, c1;
    logic [RW-1:0] r_row, n_row, r0, r1;
    logic [LW-1:0] len, cn;
    logic [31:0]   row_ext;

    function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
        return (32'(r) >= MAX_ROWS - 1) ? '0 : r + RW'(1);
    endfunction

    always_comb begin
        if (i_cfg.groups_per_row == '0) begin
            len = LW'(1);
        end else if (32'(i_cfg.groups_per_row) > MAX_GROUPS) begin
            len = LW'(MAX_GROUPS);
        end else begin
            len = LW'(i_cfg.groups_per_row);
        end
    end

    always_comb begin
        c0 = i_frame_start ? '0 : r_col;
        r0 = i_frame_start ? '0 : r_row;
        // close the row first if the row length shrank under the column
        if (LW'(c0) >= len) begin
            c1 = '0;
            r1 = row_inc(r0);
        end else begin
            c1 = c0;
            r1 = r0;
        end
        cn = LW'(c1) + LW'(1);
        if (cn >= len) begin
            n_col = '0;
            n_row = row_inc(r1);
        end else begin
            n_col = CW'(cn);
            n_row = r1;
        end
    end

    assign row_ext = 32'(r1);
    assign o_lower = i_cfg.interlaced ? row_ext[1] : row_ext[0];
    assign o_slot  = i_cfg.interlaced & row_ext[0];
    assign o_col   = c1;
    assign o_row   = r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/packed_yuv422_to_planar_yuv420.sv @@
// Packed YUYV/UYVY 4:2:2 input to 4:2:0 output with vertically averaged chroma.
//
// One macropixel is accepted per clock while o_stall is low, with no gaps
// required. Upper-row macropixels are unpacked and written into a line
// store of 2*MAX_GROUPS words (one half per field parity when interlaced)
// and produce no result. Each lower-row macropixel reads its upper partner
// from the store and produces one result, passing first through the
// registered line-store read, then the averaging and output register. A
// result waiting on o_valid does not block input; the input stalls only
// when both the read stage and the output register are full. The line store
// is not cleared at reset; reading a column that no upper row wrote gives
// undefined samples. Register writes take effect at once and are meant for
// idle periods.
`default_nettype none

module packed_yuv422_to_planar_yuv420
    import pyuv420_pkg::*;
#(
    parameter int MAX_GROUPS = 2048,
    parameter int MAX_ROWS   = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_byte_zero,
    input  wire logic [7:0]        i_byte_one,
    input  wire logic [7:0]        i_byte_two,
    input  wire logic [7:0]        i_byte_three,
    input  wire logic              i_frame_start,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [7:0]        o_luma_upper_left,
    output logic      [7:0]        o_luma_upper_right,
    output logic      [7:0]        o_luma_lower_left,
    output logic      [7:0]        o_luma_lower_right,
    output logic      [7:0]        o_chroma_u_mean,
    output logic      [7:0]        o_chroma_v_mean,
    output logic      [10:0]       o_group_column,
    output logic      [11:0]       o_upper_row
);

    localparam int CW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DEPTH = 2 * MAX_GROUPS;
    localparam int AW    = $clog2(DEPTH);

    t_cfg          cfg;
    logic          accept;
    logic          out_load;
    logic [CW-1:0] pos_col;
    logic [RW-1:0] pos_row;
    logic          pos_lower;
    logic          pos_slot;
    logic [7:0]    y0, y1, cu, cv;
    logic [AW-1:0] addr;
    logic          ram_we, ram_re;
    logic [31:0]   ram_rdata;
    logic [31:0]   col_ext;
    logic [31:0]   upper_ext;
    logic [8:0]    u_sum, v_sum;

    pyuv420_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pyuv420_pos #(
        .MAX_GROUPS (MAX_GROUPS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (accept),
        .i_frame_start (i_frame_start),
        .i_cfg         (cfg),
        .o_col         (pos_col),
        .o_row         (pos_row),
        .o_lower       (pos_lower),
        .o_slot        (pos_slot)
    );

    // read stage and output register
    logic       r_s1_valid, n_s1_valid;
    logic [7:0] r_s1_y0, r_s1_y1, r_s1_cu, r_s1_cv;
    logic [10:0] r_s1_col;
    logic [11:0] r_s1_urow;
    logic        r_out_valid;
    logic [7:0]  r_out_yul, r_out_yur, r_out_yll, r_out_ylr, r_out_u, r_out_v;
    logic [10:0] r_out_col;
    logic [11:0] r_out_urow;

    assign out_load = !r_out_valid || !i_stall;
    assign o_stall  = r_s1_valid && !out_load;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        if (cfg.uyvy_order) begin
            cu = i_byte_zero;
            y0 = i_byte_one;
            cv = i_byte_two;
            y1 = i_byte_three;
        end else begin
            y0 = i_byte_zero;
            cu = i_byte_one;
            y1 = i_byte_two;
            cv = i_byte_three;
        end
    end

    assign addr   = (pos_slot ? AW'(MAX_GROUPS) : AW'(0)) + AW'(pos_col);
    assign ram_we = accept && !pos_lower;
    assign ram_re = accept && pos_lower;

    pyuv420_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata ({cv, cu, y1, y0}),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    assign col_ext   = 32'(pos_col);
    assign upper_ext = 32'(pos_row) - (cfg.interlaced ? 32'd2 : 32'd1);

    always_comb begin
        if (ram_re) begin
            n_s1_valid = 1'b1;
        end else if (out_load) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_s1_y0   <= y0;
            r_s1_y1   <= y1;
            r_s1_cu   <= cu;
            r_s1_cv   <= cv;
            r_s1_col  <= col_ext[10:0];
            r_s1_urow <= upper_ext[11:0];
        end
    end

    assign u_sum = {1'b0, ram_rdata[23:16]} + {1'b0, r_s1_cu};
    assign v_sum = {1'b0, ram_rdata[31:24]} + {1'b0, r_s1_cv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_yul  <= ram_rdata[7:0];
            r_out_yur  <= ram_rdata[15:8];
            r_out_yll  <= r_s1_y0;
            r_out_ylr  <= r_s1_y1;
            r_out_u    <= u_sum[8:1];
            r_out_v    <= v_sum[8:1];
            r_out_col  <= r_s1_col;
            r_out_urow <= r_s1_urow;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_luma_upper_left  = r_out_yul;
    assign o_luma_upper_right = r_out_yur;
    assign o_luma_lower_left  = r_out_yll;
    assign o_luma_lower_right = r_out_ylr;
    assign o_chroma_u_mean    = r_out_u;
    assign o_chroma_v_mean    = r_out_v;
    assign o_group_column     = r_out_col;
    assign o_upper_row        = r_out_urow;

    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store written and read in the same cycle");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a pending read");

    a_s1_not_overwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_load) |=> r_s1_valid && $stable(r_s1_col))
        else $error("held read stage lost or overwritten");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(pos_row) < MAX_ROWS)
        else $error("row counter out of range");

endmodule

`default_nettype wire

@@ tb/sv/packed_yuv422_to_planar_yuv420_test.sv @@
// Self-checking testbench for the packed 4:2:2 to planar 4:2:0 converter.
module packed_yuv422_to_planar_yuv420_test
    import pyuv420_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GROUPS = 2048;
    localparam int MAX_ROWS   = 4096;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       frame_start;
    } t_macropixel;

    typedef struct packed {
        logic [7:0]  y_ul;
        logic [7:0]  y_ur;
        logic [7:0]  y_ll;
        logic [7:0]  y_lr;
        logic [7:0]  u_mean;
        logic [7:0]  v_mean;
        logic [10:0] column;
        logic [11:0] upper_row;
    } t_quad;

    typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_TOGGLE} t_pace;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [7:0]        i_byte_zero = '0;
    logic [7:0]        i_byte_one = '0;
    logic [7:0]        i_byte_two = '0;
    logic [7:0]        i_byte_three = '0;
    logic              i_frame_start = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [7:0]        o_luma_upper_left;
    logic [7:0]        o_luma_upper_right;
    logic [7:0]        o_luma_lower_left;
    logic [7:0]        o_luma_lower_right;
    logic [7:0]        o_chroma_u_mean;
    logic [7:0]        o_chroma_v_mean;
    logic [10:0]       o_group_column;
    logic [11:0]       o_upper_row;

    packed_yuv422_to_planar_yuv420 #(
        .MAX_GROUPS(MAX_GROUPS),
        .MAX_ROWS  (MAX_ROWS)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_byte_zero       (i_byte_zero),
        .i_byte_one        (i_byte_one),
        .i_byte_two        (i_byte_two),
        .i_byte_three      (i_byte_three),
        .i_frame_start     (i_frame_start),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_luma_upper_left (o_luma_upper_left),
        .o_luma_upper_right(o_luma_upper_right),
        .o_luma_lower_left (o_luma_lower_left),
        .o_luma_lower_right(o_luma_lower_right),
        .o_chroma_u_mean   (o_chroma_u_mean),
        .o_chroma_v_mean   (o_chroma_v_mean),
        .o_group_column    (o_group_column),
        .o_upper_row       (o_upper_row)
    );

    always #5 i_clk = ~i_clk;

    // Converter shadow: settings, position and the unpacked upper-row samples.
    t_cfg        model_cfg = '{groups_per_row: GROUPS_PER_ROW_RST, interlaced: 1'b0,
                               uyvy_order: 1'b0};
    logic [31:0] upper_samples [0:2*MAX_GROUPS-1];
    int          col_pos = 0;
    int          row_pos = 0;

    t_macropixel waiting_macropixels[$];
    t_quad       pending_quads[$];
    int          mismatches = 0;
    int          taken_count = 0;
    logic        taken_last = 1'b0;

    function automatic int row_groups(input logic [11:0] setting);
        if (setting == 0) return 1;
        if (setting > MAX_GROUPS) return MAX_GROUPS;
        return int'(setting);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic end_row();
        col_pos = 0;
        row_pos = (row_pos >= MAX_ROWS - 1) ? 0 : row_pos + 1;
    endtask

    task automatic downsample_macropixel(input t_macropixel mp);
        int          len;
        int          addr;
        logic        lower_row;
        logic [7:0]  y0, y1, cu, cv;
        logic [31:0] held;
        logic [8:0]  sum;
        t_quad       q;
        if (mp.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        len = row_groups(model_cfg.groups_per_row);
        // a row shortened under way ends before this request
        if (col_pos >= len) end_row();
        if (model_cfg.uyvy_order) begin
            cu = mp.b0; y0 = mp.b1; cv = mp.b2; y1 = mp.b3;
        end else begin
            y0 = mp.b0; cu = mp.b1; y1 = mp.b2; cv = mp.b3;
        end
        if (model_cfg.interlaced) begin
            lower_row = row_pos[1];
            addr = row_pos[0] * MAX_GROUPS + col_pos;
        end else begin
            lower_row = row_pos[0];
            addr = col_pos;
        end
        if (!lower_row) begin
            upper_samples[addr] = {cv, cu, y1, y0};
        end else begin
            held = upper_samples[addr];
            q.y_ul = held[7:0];
            q.y_ur = held[15:8];
            q.y_ll = y0;
            q.y_lr = y1;
            sum = held[23:16] + cu;
            q.u_mean = sum[8:1];
            sum = held[31:24] + cv;
            q.v_mean = sum[8:1];
            q.column = 11'(col_pos);
            q.upper_row = 12'(row_pos - (model_cfg.interlaced ? 2 : 1));
            pending_quads.push_back(q);
        end
        col_pos++;
        if (col_pos >= len) end_row();
    endtask

    // Record each accepted request and predict what it yields.
    always @(posedge i_clk) begin : track_requests
        taken_last <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            downsample_macropixel('{b0: i_byte_zero, b1: i_byte_one, b2: i_byte_two,
                                    b3: i_byte_three, frame_start: i_frame_start});
            taken_count++;
        end
    end

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 8;
    int gap_left = 0;

    always @(negedge i_clk) begin : drive_macropixels
        t_macropixel mp;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || taken_last) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (waiting_macropixels.size() > 0) begin
                mp = waiting_macropixels.pop_front();
                i_byte_zero   <= mp.b0;
                i_byte_one    <= mp.b1;
                i_byte_two    <= mp.b2;
                i_byte_three  <= mp.b3;
                i_frame_start <= mp.frame_start;
                i_valid       <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern of its own, plus two long hold-offs.
    t_pace pace = PACE_FREE;
    int    pace_left = 0;
    int    hold_left = 0;
    int    holds_done = 0;

    always @(negedge i_clk) begin : pace_results
        logic stall_now;
        if (hold_left > 0) begin
            hold_left--;
            stall_now = 1'b1;
        end else if ((holds_done == 0 && taken_count >= 40) ||
                     (holds_done == 1 && taken_count >= 700)) begin
            holds_done++;
            hold_left = 120;
            stall_now = 1'b1;
        end else begin
            if (pace_left == 0) begin
                pace = t_pace'($urandom_range(0, 3));
                pace_left = $urandom_range(20, 200);
            end else begin
                pace_left--;
            end
            case (pace)
                PACE_FREE:  stall_now = 1'b0;
                PACE_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
                PACE_HEAVY: stall_now = ($urandom_range(0, 3) != 0);
                default:    stall_now = ~i_stall;
            endcase
        end
        i_stall <= stall_now;
    end

    always @(posedge i_clk) begin : check_quads
        t_quad want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_quads.size() == 0) begin
                report_mismatch("unrequested result", 1, 0);
            end else begin
                want = pending_quads.pop_front();
                if (o_luma_upper_left !== want.y_ul)
                    report_mismatch("luma_upper_left", o_luma_upper_left, want.y_ul);
                if (o_luma_upper_right !== want.y_ur)
                    report_mismatch("luma_upper_right", o_luma_upper_right, want.y_ur);
                if (o_luma_lower_left !== want.y_ll)
                    report_mismatch("luma_lower_left", o_luma_lower_left, want.y_ll);
                if (o_luma_lower_right !== want.y_lr)
                    report_mismatch("luma_lower_right", o_luma_lower_right, want.y_lr);
                if (o_chroma_u_mean !== want.u_mean)
                    report_mismatch("chroma_u_mean", o_chroma_u_mean, want.u_mean);
                if (o_chroma_v_mean !== want.v_mean)
                    report_mismatch("chroma_v_mean", o_chroma_v_mean, want.v_mean);
                if (o_group_column !== want.column)
                    report_mismatch("group_column", o_group_column, want.column);
                if (o_upper_row !== want.upper_row)
                    report_mismatch("upper_row", o_upper_row, want.upper_row);
            end
        end
    end

    task automatic queue_macropixel(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input logic fs);
        waiting_macropixels.push_back('{b0: b0, b1: b1, b2: b2, b3: b3, frame_start: fs});
    endtask

    // First request opens a frame; noisy frames restart now and then.
    task automatic queue_frame(input int count, input bit noisy);
        for (int k = 0; k < count; k++)
            queue_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                             k == 0 || (noisy && $urandom_range(0, 63) == 0));
    endtask

    // Wait until every request is taken and every result is back, then settle.
    task automatic drain();
        @(posedge i_clk);
        while (waiting_macropixels.size() != 0 || i_valid || pending_quads.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [11:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = APB_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_GROUPS_PER_ROW: model_cfg.groups_per_row = value;
            REG_INTERLACED:     model_cfg.interlaced = value[0];
            REG_UYVY_ORDER:     model_cfg.uyvy_order = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apply_setting(input logic [11:0] groups, input logic il, input logic uy);
        drain();
        write_register(REG_GROUPS_PER_ROW, groups);
        write_register(REG_INTERLACED, {11'd0, il});
        write_register(REG_UYVY_ORDER, {11'd0, uy});
    endtask

    initial begin : run_stimulus
        logic [11:0] groups;
        logic        il;
        int          eff;
        int          count;
        int          frames;
        int          random_items;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes over three rows of four, progressive YUYV.
        apply_setting(12'd4, 1'b0, 1'b0);
        queue_macropixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        queue_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_macropixel(8'h01, 8'hFF, 8'h80, 8'h00, 1'b0);
        queue_macropixel(8'h7F, 8'h01, 8'hFE, 8'h80, 1'b0);
        queue_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_macropixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
        queue_macropixel(8'hAA, 8'h00, 8'h55, 8'h01, 1'b0);
        queue_macropixel(8'h80, 8'h01, 8'h7F, 8'h80, 1'b0);
        queue_macropixel(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0);
        queue_macropixel(8'hFE, 8'h7F, 8'h01, 8'hFF, 1'b0);
        queue_macropixel(8'h0F, 8'hF0, 8'h33, 8'hCC, 1'b0);
        queue_macropixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        // Switch byte order between the upper and lower row of a pair.
        drain();
        write_register(REG_UYVY_ORDER, 12'd1);
        queue_macropixel(8'hFF, 8'h00, 8'h01, 8'hFF, 1'b0);
        queue_macropixel(8'h80, 8'h80, 8'h7F, 8'h7F, 1'b0);
        queue_macropixel(8'hCC, 8'h33, 8'hF0, 8'h0F, 1'b0);
        queue_macropixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
        queue_macropixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
        queue_macropixel(8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b0);
        // Shrink the row mid-row; zero acts as one group per row.
        drain();
        write_register(REG_GROUPS_PER_ROW, 12'd0);
        queue_macropixel(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
        queue_macropixel(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
        queue_macropixel(8'h81, 8'h7E, 8'h18, 8'hE7, 1'b0);
        queue_macropixel(8'h3C, 8'hC3, 8'h66, 8'h99, 1'b0);

        // Long frame that keeps requests coming through the first hold-off.
        apply_setting(12'd8, 1'b0, 1'b0);
        queue_frame(96, 1'b0);

        // Random settings and frames; most are whole row pairs.
        random_items = 0;
        while (random_items < 900) begin
            case ($urandom_range(0, 9))
                0: groups = 12'd0;
                1: groups = 12'($urandom_range(17, 64));
                default: groups = 12'($urandom_range(1, 16));
            endcase
            il = 1'($urandom_range(0, 1));
            apply_setting(groups, il, 1'($urandom_range(0, 1)));
            eff = row_groups(groups);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames && random_items < 900; f++) begin
                count = (il ? 4 : 2) * $urandom_range(1, eff > 16 ? 1 : 3) * eff;
                if ($urandom_range(0, 3) == 0) count += $urandom_range(1, eff);
                queue_frame(count, 1'b1);
                random_items += count;
            end
        end

        // An out-of-range row length clamps to the maximum.
        apply_setting(12'd4095, 1'b0, 1'($urandom_range(0, 1)));
        queue_frame(64, 1'b0);

        drain();
        repeat (10) @(posedge i_clk);
        if (pending_quads.size() != 0)
            report_mismatch("missing results", 0, pending_quads.size());
        if (mismatches == 0) begin
            $display("packed_yuv422_to_planar_yuv420 verification clean");
        end else begin
            $display("packed_yuv422_to_planar_yuv420 verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("packed_yuv422_to_planar_yuv420 verification failed");
        $finish;
    end

endmodule

@@ packed_yuv422_to_planar_yuv420.f @@
hw/rtl/pyuv420_pkg.sv
hw/rtl/pyuv420_ram.sv
hw/rtl/pyuv420_cfg.sv
hw/rtl/pyuv420_pos.sv
hw/rtl/packed_yuv422_to_planar_yuv420.sv
tb/sv/packed_yuv422_to_planar_yuv420_test.sv
